### rtl/core/dmp_pkg.sv
// Shared types and constants for the Diameter message parser core.
// Depends on nothing; every module of the core imports it.
`timescale 1ns / 1ps
`default_nettype none

package dmp_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMMAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_CODE_A    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_CODE_B    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_CODE_C    = 2'd3;

    // Configuration reset values
    localparam logic [23:0] RST_EXPECTED_COMMAND = 24'd257;
    localparam logic [31:0] RST_WANTED_CODE_A    = 32'd264;
    localparam logic [31:0] RST_WANTED_CODE_B    = 32'd296;
    localparam logic [31:0] RST_WANTED_CODE_C    = 32'd1;

    // Event kinds
    localparam logic [1:0] EV_HEADER  = 2'd0;
    localparam logic [1:0] EV_AVP     = 2'd1;
    localparam logic [1:0] EV_PAYLOAD = 2'd2;
    localparam logic [1:0] EV_VERDICT = 2'd3;

    // Error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_SHORT       = 4'd1;
    localparam logic [3:0] ERR_VERSION     = 4'd2;
    localparam logic [3:0] ERR_LEN_SMALL   = 4'd3;
    localparam logic [3:0] ERR_LEN_EXCEEDS = 4'd4;
    localparam logic [3:0] ERR_COMMAND     = 4'd5;
    localparam logic [3:0] ERR_AVP_TRUNC   = 4'd6;
    localparam logic [3:0] ERR_AVP_LENGTH  = 4'd7;
    localparam logic [3:0] ERR_AVP_OVERRUN = 4'd8;

    // Framing constants
    localparam logic [23:0] HDR_LEN        = 24'd20;
    localparam logic [23:0] HDR_LAST_POS   = 24'd19;
    localparam logic [7:0]  DIAM_VERSION   = 8'd1;
    localparam logic [23:0] COUNT_MAX      = 24'hFFFFFF;
    localparam logic [23:0] AVP_HLEN_BASE  = 24'd8;
    localparam logic [23:0] AVP_HLEN_VEND  = 24'd12;
    localparam logic [23:0] AVP_REL_LAST   = 24'd7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_packet;
    } dmp_in_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [3:0]  error_code;
        logic [23:0] command_code;
        logic [7:0]  header_flags;
        logic [31:0] application_id;
        logic [31:0] hop_by_hop_id;
        logic [31:0] end_to_end_id;
        logic [31:0] avp_code;
        logic [7:0]  avp_flags;
        logic [23:0] avp_payload_length;
        logic [7:0]  payload_byte;
        logic        last_payload;
    } dmp_out_t;

    // One queued request: an optional header/descriptor/payload event
    // followed by an optional verdict, with the data both may need.
    typedef struct packed {
        logic        a_valid;
        logic [1:0]  a_kind;
        logic [3:0]  a_err;
        logic        v_valid;
        logic [3:0]  v_err;
        logic [23:0] command_code;
        logic [7:0]  header_flags;
        logic [31:0] application_id;
        logic [31:0] hop_by_hop_id;
        logic [31:0] end_to_end_id;
        logic [31:0] avp_code;
        logic [7:0]  avp_flags;
        logic [23:0] avp_payload_length;
        logic [7:0]  payload_byte;
        logic        last_payload;
    } dmp_rec_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic head_valid;
    } dmp_q_status_t;

endpackage

`default_nettype wire

### rtl/core/dmp_front.sv
// Front end of the parser: configuration registers, header and AVP walk.
// Classifies each accepted byte; those that yield an event or a verdict become queue requests. Uses dmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmp_front
    import dmp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 take,
    input  wire dmp_in_t              item,
    output logic                      push,
    output dmp_rec_t                  rec
);

    localparam logic [1:0] ST_HEADER = 2'd0;
    localparam logic [1:0] ST_AVPHDR = 2'd1;
    localparam logic [1:0] ST_BODY   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [23:0] exp_cmd_reg;
    logic [31:0] want_a_reg;
    logic [31:0] want_b_reg;
    logic [31:0] want_c_reg;

    logic [23:0] byte_count_reg, byte_count_next;
    logic [23:0] msg_len_reg, msg_len_next;
    logic [7:0]  version_reg, version_next;
    logic [31:0] hf0_reg, hf0_next;
    logic [31:0] hf1_reg, hf1_next;
    logic [63:0] ids_reg, ids_next;
    logic [1:0]  stage_reg, stage_next;
    logic [23:0] avp_start_reg, avp_start_next;
    logic [23:0] avp_len_reg, avp_len_next;
    logic [31:0] avp_code_reg, avp_code_next;
    logic [7:0]  avp_flags_reg, avp_flags_next;
    logic [3:0]  pend_reg, pend_next;

    logic [7:0]  b;
    logic [23:0] pos;
    logic [23:0] rel;
    logic [24:0] pos_inc;
    logic [23:0] hlen_cur;
    logic [23:0] hlen_new;
    logic [25:0] end_cur;
    logic [25:0] end_new;
    logic [25:0] enter_at;
    logic        do_enter;
    logic        wanted;
    logic [3:0]  hdr_err;
    logic [23:0] count_after;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_cmd_reg <= RST_EXPECTED_COMMAND;
            want_a_reg  <= RST_WANTED_CODE_A;
            want_b_reg  <= RST_WANTED_CODE_B;
            want_c_reg  <= RST_WANTED_CODE_C;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED_COMMAND: exp_cmd_reg <= cfg_data[23:0];
                CFG_WANTED_CODE_A:    want_a_reg  <= cfg_data;
                CFG_WANTED_CODE_B:    want_b_reg  <= cfg_data;
                CFG_WANTED_CODE_C:    want_c_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Fixed views of the current AVP
    assign b        = item.in_byte;
    assign pos      = byte_count_reg;
    assign rel      = pos - avp_start_reg;
    assign pos_inc  = {1'b0, pos} + 25'd1;
    assign hlen_cur = avp_flags_reg[7] ? AVP_HLEN_VEND : AVP_HLEN_BASE;
    assign end_cur  = {2'b00, avp_start_reg}
                    + (({2'b00, avp_len_reg} + 26'd3) & ~26'd3);
    assign wanted   = (avp_code_reg == want_a_reg) || (avp_code_reg == want_b_reg)
                   || (avp_code_reg == want_c_reg);

    // Advance the walk by one byte
    always_comb
    begin
        byte_count_next = byte_count_reg;
        msg_len_next    = msg_len_reg;
        version_next    = version_reg;
        hf0_next        = hf0_reg;
        hf1_next        = hf1_reg;
        ids_next        = ids_reg;
        stage_next      = stage_reg;
        avp_start_next  = avp_start_reg;
        avp_len_next    = avp_len_reg;
        avp_code_next   = avp_code_reg;
        avp_flags_next  = avp_flags_reg;
        pend_next       = pend_reg;
        rec             = '0;
        do_enter        = 1'b0;
        enter_at        = '0;
        hlen_new        = AVP_HLEN_BASE;
        end_new         = '0;
        hdr_err         = ERR_NONE;
        count_after     = byte_count_reg;

        if (take)
        begin
            case (stage_reg)
                ST_HEADER:
                begin
                    if (pos == 24'd0)
                        version_next = b;
                    else if (pos <= 24'd3)
                        msg_len_next = {msg_len_reg[15:0], b};
                    else if (pos <= 24'd7)
                        hf0_next = {hf0_reg[23:0], b};
                    else if (pos <= 24'd11)
                        hf1_next = {hf1_reg[23:0], b};
                    else if (pos <= HDR_LAST_POS)
                        ids_next = {ids_reg[55:0], b};

                    if (pos == HDR_LAST_POS)
                    begin
                        if (version_next != DIAM_VERSION)
                            hdr_err = ERR_VERSION;
                        else if (msg_len_next < HDR_LEN)
                            hdr_err = ERR_LEN_SMALL;
                        else if (hf0_next[23:0] != exp_cmd_reg || !hf0_next[31])
                            hdr_err = ERR_COMMAND;
                        pend_next   = hdr_err;
                        rec.a_valid = 1'b1;
                        rec.a_kind  = EV_HEADER;
                        rec.a_err   = hdr_err;
                        if (hdr_err != ERR_NONE)
                            stage_next = ST_DONE;
                        else
                        begin
                            do_enter = 1'b1;
                            enter_at = {2'b00, HDR_LEN};
                        end
                    end
                end

                ST_AVPHDR:
                begin
                    if (rel <= 24'd3)
                        avp_code_next = {avp_code_reg[23:0], b};
                    else if (rel == 24'd4)
                        avp_flags_next = b;
                    else
                        avp_len_next = {avp_len_reg[15:0], b};

                    if (rel == AVP_REL_LAST)
                    begin
                        hlen_new = avp_flags_next[7] ? AVP_HLEN_VEND : AVP_HLEN_BASE;
                        end_new  = {2'b00, avp_start_reg}
                                 + (({2'b00, avp_len_next} + 26'd3) & ~26'd3);
                        if (avp_len_next < hlen_new)
                        begin
                            pend_next  = ERR_AVP_LENGTH;
                            stage_next = ST_DONE;
                        end
                        else if (({1'b0, avp_start_reg} + {1'b0, avp_len_next})
                                 > {1'b0, msg_len_reg})
                        begin
                            pend_next  = ERR_AVP_OVERRUN;
                            stage_next = ST_DONE;
                        end
                        else
                        begin
                            rec.a_valid            = 1'b1;
                            rec.a_kind             = EV_AVP;
                            rec.avp_payload_length = avp_len_next - hlen_new;
                            if ({1'b0, pos_inc} == end_new
                                || pos_inc == {1'b0, msg_len_reg})
                            begin
                                do_enter = 1'b1;
                                enter_at = end_new;
                            end
                            else
                                stage_next = ST_BODY;
                        end
                    end
                end

                ST_BODY:
                begin
                    if (rel >= hlen_cur && rel < avp_len_reg && wanted)
                    begin
                        rec.a_valid            = 1'b1;
                        rec.a_kind             = EV_PAYLOAD;
                        rec.avp_payload_length = avp_len_reg - hlen_cur;
                        rec.payload_byte       = b;
                        rec.last_payload       = ({1'b0, rel} + 25'd1) == {1'b0, avp_len_reg};
                    end
                    if ({1'b0, pos_inc} == end_cur || pos_inc == {1'b0, msg_len_reg})
                    begin
                        do_enter = 1'b1;
                        enter_at = end_cur;
                    end
                end

                default: ;
            endcase

            // Move to the next AVP or finish the walk
            if (do_enter)
            begin
                if (enter_at >= {2'b00, msg_len_next})
                    stage_next = ST_DONE;
                else if ((enter_at + 26'd8) > {2'b00, msg_len_next})
                begin
                    pend_next  = ERR_AVP_TRUNC;
                    stage_next = ST_DONE;
                end
                else
                begin
                    avp_start_next = enter_at[23:0];
                    stage_next     = ST_AVPHDR;
                end
            end

            // Saturating byte counter
            if (byte_count_reg != COUNT_MAX)
                count_after = byte_count_reg + 24'd1;
            byte_count_next = count_after;

            // Snapshot header and AVP data for the queued request
            rec.command_code   = hf0_next[23:0];
            rec.header_flags   = hf0_next[31:24];
            rec.application_id = hf1_next;
            rec.hop_by_hop_id  = ids_next[63:32];
            rec.end_to_end_id  = ids_next[31:0];
            rec.avp_code       = avp_code_next;
            rec.avp_flags      = avp_flags_next;

            // Close the packet: verdict and re-arm
            if (item.end_of_packet)
            begin
                rec.v_valid = 1'b1;
                if (count_after < HDR_LEN)
                    rec.v_err = ERR_SHORT;
                else if (pend_next == ERR_VERSION || pend_next == ERR_LEN_SMALL)
                    rec.v_err = pend_next;
                else if (count_after < msg_len_next)
                    rec.v_err = ERR_LEN_EXCEEDS;
                else
                    rec.v_err = pend_next;

                byte_count_next = '0;
                msg_len_next    = '0;
                version_next    = '0;
                hf0_next        = '0;
                hf1_next        = '0;
                ids_next        = '0;
                stage_next      = ST_HEADER;
                avp_start_next  = HDR_LEN;
                avp_len_next    = '0;
                avp_code_next   = '0;
                avp_flags_next  = '0;
                pend_next       = ERR_NONE;
            end
        end
    end

    assign push = take && (rec.a_valid || rec.v_valid);

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            msg_len_reg    <= '0;
            version_reg    <= '0;
            hf0_reg        <= '0;
            hf1_reg        <= '0;
            ids_reg        <= '0;
            stage_reg      <= ST_HEADER;
            avp_start_reg  <= HDR_LEN;
            avp_len_reg    <= '0;
            avp_code_reg   <= '0;
            avp_flags_reg  <= '0;
            pend_reg       <= ERR_NONE;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            msg_len_reg    <= msg_len_next;
            version_reg    <= version_next;
            hf0_reg        <= hf0_next;
            hf1_reg        <= hf1_next;
            ids_reg        <= ids_next;
            stage_reg      <= stage_next;
            avp_start_reg  <= avp_start_next;
            avp_len_reg    <= avp_len_next;
            avp_code_reg   <= avp_code_next;
            avp_flags_reg  <= avp_flags_next;
            pend_reg       <= pend_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/dmp_queue.sv
// Short request queue between the parser front and the result back end.
// Register-based ring of dmp_rec_t entries. Uses dmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmp_queue
    import dmp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire dmp_rec_t   push_rec,
    input  wire logic       pop,
    output dmp_rec_t        head,
    output dmp_q_status_t   status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dmp_rec_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign do_push = push && (count_reg != CNT_FULL);
    assign do_pop  = pop && (count_reg != '0);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    assign head              = entry_reg[rd_ptr_reg];
    assign status.head_valid = (count_reg != '0);
    assign status.full       = (count_reg == CNT_FULL);

endmodule

`default_nettype wire

### rtl/core/dmp_back.sv
// Back end of the parser: expands queued requests into result items.
// Drives the output register. Uses dmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmp_back
    import dmp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dmp_rec_t head,
    input  wire logic     head_valid,
    input  wire logic     out_stall,
    output logic          pop,
    output logic          out_valid,
    output dmp_out_t      out_data
);

    logic     out_valid_reg, out_valid_next;
    dmp_out_t out_data_reg, out_data_next;
    logic     second_reg, second_next;
    logic     load;
    logic     emit_a;
    logic     hdr_on;
    logic     avp_on;
    logic     pay_on;

    assign load   = !out_valid_reg || !out_stall;
    assign emit_a = head.a_valid && !second_reg;
    assign hdr_on = emit_a ? (head.a_kind == EV_HEADER) : 1'b1;
    assign avp_on = emit_a && (head.a_kind == EV_AVP || head.a_kind == EV_PAYLOAD);
    assign pay_on = emit_a && (head.a_kind == EV_PAYLOAD);

    // Build the next result from the head request
    always_comb
    begin
        out_data_next.event_res          = emit_a ? head.a_kind : EV_VERDICT;
        out_data_next.error_code         = emit_a ? head.a_err : head.v_err;
        out_data_next.command_code       = hdr_on ? head.command_code : '0;
        out_data_next.header_flags       = hdr_on ? head.header_flags : '0;
        out_data_next.application_id     = hdr_on ? head.application_id : '0;
        out_data_next.hop_by_hop_id      = hdr_on ? head.hop_by_hop_id : '0;
        out_data_next.end_to_end_id      = hdr_on ? head.end_to_end_id : '0;
        out_data_next.avp_code           = avp_on ? head.avp_code : '0;
        out_data_next.avp_flags          = avp_on ? head.avp_flags : '0;
        out_data_next.avp_payload_length = avp_on ? head.avp_payload_length : '0;
        out_data_next.payload_byte       = pay_on ? head.payload_byte : '0;
        out_data_next.last_payload       = pay_on ? head.last_payload : 1'b0;
    end

    // Drop the request once its last result is loaded
    assign pop = load && head_valid && !(emit_a && head.v_valid);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        second_next    = second_reg;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
                second_next = emit_a && head.v_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    // Hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (load && head_valid)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/core/diameter_message_parser_core.sv
// Diameter message parser core: top level tying front, queue and back end.
// Depends on dmp_pkg, dmp_front, dmp_queue and dmp_back.
//
// Usage: message bytes enter on in_valid/in_stall/in_data, one request per
// cycle while in_stall is low, with end_of_packet on the last byte. Results
// leave on out_valid/out_stall/out_data: a header event on byte 19, a
// descriptor per AVP, payload bytes of the three selected AVP codes, and a
// verdict on the end-of-packet byte. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// The first result of a byte is registered in the queue and then in the
// output register. A byte that yields two results (any event plus the
// verdict) holds the output for both, and the FIFO_DEPTH-entry queue
// absorbs that. in_stall rises only while the queue is full.
// Reset: configuration returns to its defaults, the parser re-arms at the
// header, the queue empties and out_valid drops.
// Receiver stall: the output register holds its result; the queue fills and
// then in_stall is raised.
`timescale 1ns / 1ps
`default_nettype none

module diameter_message_parser_core
    import dmp_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire dmp_in_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output dmp_out_t                  out_data
);

    logic          take;
    logic          push;
    logic          pop;
    dmp_rec_t      push_rec;
    dmp_rec_t      head;
    dmp_q_status_t q_status;

    assign in_stall = q_status.full;
    assign take     = in_valid && !q_status.full;

    dmp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (in_data),
        .push      (push),
        .rec       (push_rec)
    );

    dmp_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    dmp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (q_status.head_valid),
        .out_stall  (out_stall),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

    // Header fields appear only in header events and verdicts
    a_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_res == EV_AVP || out_data.event_res == EV_PAYLOAD)
        |-> (out_data.command_code == '0 && out_data.application_id == '0
             && out_data.hop_by_hop_id == '0 && out_data.end_to_end_id == '0))
        else $error("header fields leak into an AVP event");

    // Payload marks appear only on payload events
    a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_payload |-> out_data.event_res == EV_PAYLOAD)
        else $error("last_payload set outside a payload event");

    // Non-verdict, non-header events never carry an error
    a_event_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_res == EV_AVP || out_data.event_res == EV_PAYLOAD)
        |-> out_data.error_code == ERR_NONE)
        else $error("AVP event carries an error code");

    // Verdict codes stay within the defined set
    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_res == EV_VERDICT
        |-> out_data.error_code <= ERR_AVP_OVERRUN)
        else $error("verdict code out of range");

    // An empty queue never pops and never feeds a fresh result
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_status.head_valid |-> !pop)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

### tb/diameter_message_parser_core_tb.sv
// Self-checking testbench for the Diameter message parser core.
// Depends on dmp_pkg and diameter_message_parser_core; predicts every
// header, descriptor, payload and verdict event and checks them in order.
`timescale 1ns / 1ps

module diameter_message_parser_core_tb;
    import dmp_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTED    = 40;

    typedef enum logic [1:0] {
        STG_HEADER,
        STG_AVP_HDR,
        STG_BODY,
        STG_DONE
    } walk_stage_t;

    // DUT ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_EXPECTED_COMMAND;
    logic [31:0]          cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    dmp_in_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    dmp_out_t             out_data;

    // Traffic shaping
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int mismatch_count = 0;
    int bytes_sent    = 0;
    int checked_count = 0;

    // Predicted configuration
    logic [23:0] cmd_cfg = RST_EXPECTED_COMMAND;
    logic [31:0] want_a  = RST_WANTED_CODE_A;
    logic [31:0] want_b  = RST_WANTED_CODE_B;
    logic [31:0] want_c  = RST_WANTED_CODE_C;

    // Predicted parser state
    logic [31:0] count_q;
    logic [31:0] msg_len_q;
    logic [7:0]  version_q;
    logic [31:0] flags_cmd_q;
    logic [31:0] app_id_q;
    logic [63:0] ids_q;
    walk_stage_t stage_q;
    logic [31:0] avp_base_q;
    logic [31:0] avp_len_q;
    logic [31:0] avp_code_q;
    logic [7:0]  avp_flags_q;
    logic [3:0]  pend_q;

    dmp_out_t   expected_events[$];
    logic [7:0] pkt_bytes[$];
    int         msg_declared;
    int         last_pad;

    diameter_message_parser_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------

    function automatic void clear_walk();
        count_q     = '0;
        msg_len_q   = '0;
        version_q   = '0;
        flags_cmd_q = '0;
        app_id_q    = '0;
        ids_q       = '0;
        stage_q     = STG_HEADER;
        avp_base_q  = 32'd20;
        avp_len_q   = '0;
        avp_code_q  = '0;
        avp_flags_q = '0;
        pend_q      = ERR_NONE;
    endfunction

    function automatic dmp_out_t make_event(logic [1:0] kind, logic [3:0] err, bit hdr,
                                            bit avp, logic [7:0] pbyte, logic plast);
        dmp_out_t    e;
        logic [31:0] hl;
        hl = avp_flags_q[7] ? 32'd12 : 32'd8;
        e = '0;
        e.event_res  = kind;
        e.error_code = err;
        if (hdr)
        begin
            e.command_code   = flags_cmd_q[23:0];
            e.header_flags   = flags_cmd_q[31:24];
            e.application_id = app_id_q;
            e.hop_by_hop_id  = ids_q[63:32];
            e.end_to_end_id  = ids_q[31:0];
        end
        if (avp)
        begin
            e.avp_code  = avp_code_q;
            e.avp_flags = avp_flags_q;
            if (avp_len_q >= hl)
                e.avp_payload_length = avp_len_q - hl;
        end
        e.payload_byte = pbyte;
        e.last_payload = plast;
        return e;
    endfunction

    // Queue one predicted result behind the others
    function automatic void add_expected(dmp_out_t e);
        expected_events.insert(expected_events.size(), e);
    endfunction

    // Move to the AVP starting at next, or end the walk
    function automatic void enter_avp(logic [31:0] next);
        if (next >= msg_len_q)
            stage_q = STG_DONE;
        else if (next + 32'd8 > msg_len_q)
        begin
            pend_q  = ERR_AVP_TRUNC;
            stage_q = STG_DONE;
        end
        else
        begin
            avp_base_q = next;
            stage_q    = STG_AVP_HDR;
        end
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic eop);
        logic [31:0] pos;
        logic [31:0] rel;
        logic [31:0] hl;
        logic [31:0] seg_end;
        logic [3:0]  v;
        pos = count_q;
        if (stage_q == STG_HEADER)
        begin
            // Shift header fields in, big-endian
            if (pos == 0)
                version_q = b;
            else if (pos <= 3)
                msg_len_q = {8'd0, msg_len_q[15:0], b};
            else if (pos <= 7)
                flags_cmd_q = {flags_cmd_q[23:0], b};
            else if (pos <= 11)
                app_id_q = {app_id_q[23:0], b};
            else if (pos <= 19)
                ids_q = {ids_q[55:0], b};
            if (pos == 19)
            begin
                if (version_q != DIAM_VERSION)
                    pend_q = ERR_VERSION;
                else if (msg_len_q < HDR_LEN)
                    pend_q = ERR_LEN_SMALL;
                else if (flags_cmd_q[23:0] != cmd_cfg || !flags_cmd_q[31])
                    pend_q = ERR_COMMAND;
                add_expected(make_event(EV_HEADER, pend_q, 1'b1, 1'b0, '0, 1'b0));
                if (pend_q != ERR_NONE)
                    stage_q = STG_DONE;
                else
                    enter_avp(32'd20);
            end
        end
        else if (stage_q == STG_AVP_HDR || stage_q == STG_BODY)
        begin
            rel     = pos - avp_base_q;
            hl      = avp_flags_q[7] ? 32'd12 : 32'd8;
            seg_end = avp_base_q + ((avp_len_q + 32'd3) & ~32'd3);
            if (stage_q == STG_AVP_HDR)
            begin
                // Collect code, flags and length of the AVP header
                if (rel <= 3)
                    avp_code_q = {avp_code_q[23:0], b};
                else if (rel == 4)
                    avp_flags_q = b;
                else
                    avp_len_q = {8'd0, avp_len_q[15:0], b};
                if (rel == 7)
                begin
                    hl      = avp_flags_q[7] ? 32'd12 : 32'd8;
                    seg_end = avp_base_q + ((avp_len_q + 32'd3) & ~32'd3);
                    if (avp_len_q < hl)
                    begin
                        pend_q  = ERR_AVP_LENGTH;
                        stage_q = STG_DONE;
                    end
                    else if (avp_base_q + avp_len_q > msg_len_q)
                    begin
                        pend_q  = ERR_AVP_OVERRUN;
                        stage_q = STG_DONE;
                    end
                    else
                    begin
                        add_expected(make_event(EV_AVP, ERR_NONE, 1'b0, 1'b1, '0, 1'b0));
                        if (pos + 1 == seg_end || pos + 1 == msg_len_q)
                            enter_avp(seg_end);
                        else
                            stage_q = STG_BODY;
                    end
                end
            end
            else
            begin
                // Pass payload on only for the selected codes; skip vendor id and padding
                if (rel >= hl && rel < avp_len_q &&
                    (avp_code_q == want_a || avp_code_q == want_b || avp_code_q == want_c))
                    add_expected(make_event(EV_PAYLOAD, ERR_NONE, 1'b0, 1'b1, b,
                                            (rel + 1 == avp_len_q)));
                if (pos + 1 == seg_end || pos + 1 == msg_len_q)
                    enter_avp(seg_end);
            end
        end

        if (count_q < {8'd0, COUNT_MAX})
            count_q = count_q + 1;

        if (eop)
        begin
            if (count_q < HDR_LEN)
                v = ERR_SHORT;
            else if (pend_q == ERR_VERSION || pend_q == ERR_LEN_SMALL)
                v = pend_q;
            else if (count_q < msg_len_q)
                v = ERR_LEN_EXCEEDS;
            else
                v = pend_q;
            add_expected(make_event(EV_VERDICT, v, 1'b1, 1'b0, '0, 1'b0));
            clear_walk();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t ns, result %0d: %s", $time, checked_count, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        dmp_out_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_events.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = expected_events.pop_front();
                check_field("event_res", out_data.event_res, want.event_res);
                check_field("error_code", out_data.error_code, want.error_code);
                check_field("command_code", out_data.command_code, want.command_code);
                check_field("header_flags", out_data.header_flags, want.header_flags);
                check_field("application_id", out_data.application_id, want.application_id);
                check_field("hop_by_hop_id", out_data.hop_by_hop_id, want.hop_by_hop_id);
                check_field("end_to_end_id", out_data.end_to_end_id, want.end_to_end_id);
                check_field("avp_code", out_data.avp_code, want.avp_code);
                check_field("avp_flags", out_data.avp_flags, want.avp_flags);
                check_field("avp_payload_length", out_data.avp_payload_length,
                            want.avp_payload_length);
                check_field("payload_byte", out_data.payload_byte, want.payload_byte);
                check_field("last_payload", out_data.last_payload, want.last_payload);
            end
            checked_count++;
        end
    end

    // Count cycles with no request moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic eop);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid               = 1'b1;
        in_data.in_byte        = b;
        in_data.end_of_packet  = eop;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(b, eop);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        bytes_sent += pkt_bytes.size();
    endtask

    // Drop valid, wait for every predicted result, then let the core settle
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_EXPECTED_COMMAND: cmd_cfg = value[23:0];
            CFG_WANTED_CODE_A:    want_a  = value;
            CFG_WANTED_CODE_B:    want_b  = value;
            default:              want_c  = value;
        endcase
    endtask

    task automatic load_config(input logic [31:0] cmd, input logic [31:0] a,
                               input logic [31:0] b, input logic [31:0] c);
        drain_results();
        write_register(CFG_EXPECTED_COMMAND, cmd);
        write_register(CFG_WANTED_CODE_A, a);
        write_register(CFG_WANTED_CODE_B, b);
        write_register(CFG_WANTED_CODE_C, c);
    endtask

    // ------------------------------------------------------------------
    // Message building
    // ------------------------------------------------------------------

    function automatic void push_be(logic [31:0] value, int n);
        for (int k = n - 1; k >= 0; k--)
            pkt_bytes.insert(pkt_bytes.size(), value[8*k +: 8]);
    endfunction

    function automatic void set_be(int offset, logic [31:0] value, int n);
        for (int k = 0; k < n; k++)
            pkt_bytes[offset + k] = value[8*(n-1-k) +: 8];
    endfunction

    function automatic logic [31:0] pick_code(bit only_wanted);
        logic [31:0] c;
        if (only_wanted)
            return want_a;
        case ($urandom_range(0, 5))
            0: c = want_a;
            1: c = want_b;
            2: c = want_c;
            3: c = $urandom;
            4: c = want_a ^ (32'd1 << $urandom_range(0, 31));
            default: c = $urandom_range(0, 300);
        endcase
        return c;
    endfunction

    // Build a well-formed request with padded AVPs; the length covers every byte
    task automatic build_request(input int n_avp, input int pay_lo, input int pay_hi,
                                 input bit only_wanted);
        logic [7:0] fl;
        int         plen;
        int         hl;
        pkt_bytes.delete();
        last_pad = 0;
        push_be(32'd1, 1);
        push_be(32'd0, 3);
        push_be({24'd0, 8'h80 | ($urandom & 8'h7F)}, 1);
        push_be({8'd0, cmd_cfg}, 3);
        push_be($urandom, 4);
        push_be($urandom, 4);
        push_be($urandom, 4);
        for (int i = 0; i < n_avp; i++)
        begin
            fl   = $urandom;
            hl   = fl[7] ? 12 : 8;
            plen = $urandom_range(pay_lo, pay_hi);
            push_be(pick_code(only_wanted), 4);
            push_be({24'd0, fl}, 1);
            push_be(hl + plen, 3);
            if (fl[7])
                push_be($urandom, 4);
            for (int k = 0; k < plen; k++)
                push_be($urandom, 1);
            last_pad = (4 - plen % 4) % 4;
            for (int k = 0; k < last_pad; k++)
                push_be($urandom, 1);
        end
        msg_declared = pkt_bytes.size();
        set_be(1, msg_declared, 3);
    endtask

    // Well-formed requests in 9 of 20 cases; the rest carry one error or are noise
    task automatic send_random_message();
        int         kind;
        int         n;
        logic [7:0] v;
        kind = $urandom_range(0, 19);
        build_request((kind == 5 || kind == 6) ? $urandom_range(1, 3) : $urandom_range(0, 3),
                      0, ($urandom_range(0, 7) == 0) ? 20 : 6, 1'b0);
        case (kind)
            0:
            begin
                v = $urandom;
                if (v == DIAM_VERSION)
                    v = 8'd0;
                pkt_bytes[0] = v;
            end
            1: set_be(1, $urandom_range(0, 19), 3);
            2: set_be(5, {8'd0, cmd_cfg ^ (24'd1 << $urandom_range(0, 23))}, 3);
            3: pkt_bytes[4][7] = 1'b0;
            4:
            begin
                // Leave fewer than eight bytes for a further AVP header
                n = $urandom_range(1, 7);
                for (int k = 0; k < n; k++)
                    push_be($urandom, 1);
                set_be(1, msg_declared + n, 3);
            end
            5: set_be(25, $urandom_range(0, pkt_bytes[24][7] ? 11 : 7), 3);
            6:
            begin
                if ($urandom_range(0, 3) == 0)
                    set_be(25, 32'hFFFFFF, 3);
                else
                    set_be(25, msg_declared - 20 + $urandom_range(1, 40), 3);
            end
            7:
            begin
                n = $urandom_range(1, pkt_bytes.size() - 1);
                while (pkt_bytes.size() > n)
                    void'(pkt_bytes.pop_back());
            end
            8:
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    push_be($urandom, 1);
            end
            9:
            begin
                pkt_bytes.delete();
                n = $urandom_range(1, 24);
                for (int k = 0; k < n; k++)
                    push_be($urandom, 1);
            end
            10: set_be(1, msg_declared - last_pad, 3);
            default: ;
        endcase
        send_packet();
    endtask

    task automatic run_random_traffic(input int send_pct, input int stall_level,
                                      input int byte_target);
        int start;
        send_idle_pct = send_pct;
        stall_pct     = stall_level;
        start         = bytes_sent;
        while (bytes_sent - start < byte_target)
            send_random_message();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short packet, a minimal header-only request and a one-byte packet
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        pkt_bytes = '{8'h00, 8'hFF};
        send_packet();
        pkt_bytes = '{8'h01, 8'h00, 8'h00, 8'h14, 8'hFF, 8'h00, 8'h01, 8'h01,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h80, 8'h00, 8'h00, 8'h7F};
        send_packet();
        pkt_bytes = '{8'h01};
        send_packet();
    endtask

    task automatic test_no_idle();
        run_random_traffic(0, 0, 50);
    endtask

    task automatic test_sender_idle();
        load_config(32'd0, 32'd0, 32'hFFFFFFFF, $urandom_range(0, 300));
        run_random_traffic(52, 0, 50);
    endtask

    task automatic test_receiver_stall();
        load_config(32'hFFFFFFFF, $urandom, $urandom_range(0, 300), 32'hFFFFFFFF);
        run_random_traffic(0, 52, 50);
    endtask

    task automatic test_both_idle();
        load_config($urandom, $urandom_range(250, 300), $urandom, 32'd0);
        run_random_traffic(19, 19, 50);
    endtask

    // Hold the receiver off while a payload-heavy request keeps arriving
    task automatic test_long_hold();
        load_config(RST_EXPECTED_COMMAND, RST_WANTED_CODE_A, RST_WANTED_CODE_B,
                    RST_WANTED_CODE_C);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 120;
        build_request(4, 8, 16, 1'b1);
        send_packet();
    endtask

    // Let every result out before each further request
    task automatic test_drain_pause();
        send_idle_pct = 19;
        stall_pct     = 19;
        for (int i = 0; i < 3; i++)
        begin
            send_random_message();
            drain_results();
        end
    endtask

    initial
    begin
        clear_walk();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_long_hold();
        test_drain_pause();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
